// ----- hw/rtl/lddiv_pkg.sv -----
`default_nettype none

package lddiv_pkg;

  // Width of the payload ports; the arithmetic width is a parameter of the top level.
  localparam int unsigned WORD_WIDTH = 64;

  // Commands from the controller to the datapath. At most one is high in a cycle.
  typedef struct packed {
    logic load;       // capture a new word and take operand magnitudes
    logic norm_step;  // shift the divisor left by one place
    logic div_step;   // one restoring shift-subtract step
    logic commit;     // apply signs and write the output registers
  } cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic den_zero;   // captured divisor was zero
    logic norm_done;  // divisor top bit set or divisor no longer below dividend
    logic div_last;   // the current step is the final quotient bit
  } status_t;

endpackage

`default_nettype wire

// ----- hw/rtl/long_division_divider.sv -----
// Flow: a word accepted with divisor shift count k (0 to DATA_WIDTH-1) goes through load,
// normalization, the restoring steps and the sign fix; a zero divisor skips the restoring steps.
// The single shared shift-subtract unit first normalizes the divisor and then makes one quotient
// bit a cycle; a new word is accepted only once the previous one has left the sign fix.
// A result still stalled at the output holds the next word in its sign fix.
// Reset: synchronous, active high; clears the controller state and the result valid flag.
`default_nettype none

module long_division_divider #(
  parameter int unsigned DATA_WIDTH = 64
) (
  input  wire logic                             clk,
  input  wire logic                             rst,
  input  wire logic                             req_valid,
  output logic                                  req_stall,
  input  wire logic                             req_type,
  input  wire logic [lddiv_pkg::WORD_WIDTH-1:0] dividend,
  input  wire logic [lddiv_pkg::WORD_WIDTH-1:0] divisor,
  output logic                                  rsp_valid,
  input  wire logic                             rsp_stall,
  output logic      [lddiv_pkg::WORD_WIDTH-1:0] quotient,
  output logic      [lddiv_pkg::WORD_WIDTH-1:0] remainder,
  output logic                                  divide_by_zero
);

  // The controller walks one word through load, normalization, the restoring steps and
  // the sign fix. The datapath holds the working dividend, divisor, quotient and step
  // count. Only bits below DATA_WIDTH of the operands are used; result bits above are zero.
  // The output register is separate from the working registers, so a new word is taken
  // while the previous result still waits for the receiver.

  lddiv_pkg::cmd_t    cmd;
  lddiv_pkg::status_t status;

  lddiv_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req_valid),
    .req_stall (req_stall),
    .rsp_valid (rsp_valid),
    .rsp_stall (rsp_stall),
    .cmd       (cmd),
    .status    (status)
  );

  lddiv_datapath #(
    .DATA_WIDTH (DATA_WIDTH)
  ) u_datapath (
    .clk            (clk),
    .cmd            (cmd),
    .status         (status),
    .req_type       (req_type),
    .dividend       (dividend),
    .divisor        (divisor),
    .quotient       (quotient),
    .remainder      (remainder),
    .divide_by_zero (divide_by_zero)
  );

  // The controller never issues two datapath commands in the same cycle.
  assert property (@(posedge clk) disable iff (rst)
    $onehot0({cmd.load, cmd.norm_step, cmd.div_step, cmd.commit}))
    else $error("more than one datapath command at once");

  // An accepted word keeps the input side closed on the following cycle.
  assert property (@(posedge clk) disable iff (rst)
    (req_valid && !req_stall) |=> req_stall)
    else $error("input reopened right after accepting a word");

  // A commit always leaves a valid result in the output register.
  assert property (@(posedge clk) disable iff (rst)
    cmd.commit |=> rsp_valid)
    else $error("committed result not presented");

  // A zero divisor result carries zero quotient and remainder.
  assert property (@(posedge clk) disable iff (rst)
    (rsp_valid && divide_by_zero) |-> (quotient == '0 && remainder == '0))
    else $error("divide by zero result not cleared");

endmodule

`default_nettype wire

// ----- hw/rtl/lddiv_datapath.sv -----
`default_nettype none

module lddiv_datapath #(
  parameter int unsigned DATA_WIDTH = 64
) (
  input  wire logic                                  clk,
  input  wire lddiv_pkg::cmd_t                       cmd,
  output lddiv_pkg::status_t                         status,
  input  wire logic                                  req_type,
  input  wire logic [lddiv_pkg::WORD_WIDTH-1:0]      dividend,
  input  wire logic [lddiv_pkg::WORD_WIDTH-1:0]      divisor,
  output logic      [lddiv_pkg::WORD_WIDTH-1:0]      quotient,
  output logic      [lddiv_pkg::WORD_WIDTH-1:0]      remainder,
  output logic                                       divide_by_zero
);

  localparam int unsigned CW = $clog2(DATA_WIDTH);

  logic [DATA_WIDTH-1:0] num;
  logic [DATA_WIDTH-1:0] den;
  logic [DATA_WIDTH-1:0] quo;
  logic [CW-1:0]         cnt;
  logic                  dz;
  logic                  neg_q;
  logic                  neg_r;

  logic [DATA_WIDTH-1:0] a_in;
  logic [DATA_WIDTH-1:0] b_in;
  logic                  a_neg;
  logic                  b_neg;
  logic                  ge;
  logic [DATA_WIDTH-1:0] q_fix;
  logic [DATA_WIDTH-1:0] r_fix;

  logic [DATA_WIDTH-1:0] q_out;
  logic [DATA_WIDTH-1:0] r_out;

  assign a_in  = dividend[DATA_WIDTH-1:0];
  assign b_in  = divisor[DATA_WIDTH-1:0];
  assign a_neg = req_type & a_in[DATA_WIDTH-1];
  assign b_neg = req_type & b_in[DATA_WIDTH-1];

  assign ge    = (den <= num);
  assign q_fix = neg_q ? (~quo + DATA_WIDTH'(1)) : quo;
  assign r_fix = neg_r ? (~num + DATA_WIDTH'(1)) : num;

  assign status.den_zero  = dz;
  assign status.norm_done = den[DATA_WIDTH-1] | (den >= num);
  assign status.div_last  = (cnt == '0);

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      num   <= a_neg ? (~a_in + DATA_WIDTH'(1)) : a_in;
      den   <= b_neg ? (~b_in + DATA_WIDTH'(1)) : b_in;
      quo   <= '0;
      cnt   <= '0;
      dz    <= (b_in == '0);
      neg_q <= a_neg ^ b_neg;
      neg_r <= a_neg;
    end else if (cmd.norm_step) begin
      den <= {den[DATA_WIDTH-2:0], 1'b0};
      cnt <= cnt + CW'(1);
    end else if (cmd.div_step) begin
      quo <= {quo[DATA_WIDTH-2:0], ge};
      if (ge) begin
        num <= num - den;
      end
      den <= {1'b0, den[DATA_WIDTH-1:1]};
      cnt <= cnt - CW'(1);
    end
  end

  // Output registers hold a finished word while the datapath works on the next one.
  always_ff @(posedge clk) begin
    if (cmd.commit) begin
      q_out          <= dz ? '0 : q_fix;
      r_out          <= dz ? '0 : r_fix;
      divide_by_zero <= dz;
    end
  end

  always_comb begin
    quotient                   = '0;
    remainder                  = '0;
    quotient[DATA_WIDTH-1:0]   = q_out;
    remainder[DATA_WIDTH-1:0]  = r_out;
  end

endmodule

`default_nettype wire

// ----- hw/rtl/lddiv_ctrl.sv -----
`default_nettype none

module lddiv_ctrl (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               req_valid,
  output logic                    req_stall,
  output logic                    rsp_valid,
  input  wire logic               rsp_stall,
  output lddiv_pkg::cmd_t         cmd,
  input  wire lddiv_pkg::status_t status
);

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_NORM = 2'd1;
  localparam logic [1:0] ST_DIV  = 2'd2;
  localparam logic [1:0] ST_FIX  = 2'd3;

  logic [1:0] state;
  logic [1:0] state_next;
  logic       rsp_valid_next;

  assign req_stall = (state != ST_IDLE);

  always_comb begin
    state_next = state;
    cmd        = '0;
    unique case (state)
      ST_IDLE: begin
        if (req_valid) begin
          cmd.load   = 1'b1;
          state_next = ST_NORM;
        end
      end
      ST_NORM: begin
        if (status.den_zero) begin
          state_next = ST_FIX;
        end else if (status.norm_done) begin
          state_next = ST_DIV;
        end else begin
          cmd.norm_step = 1'b1;
        end
      end
      ST_DIV: begin
        cmd.div_step = 1'b1;
        if (status.div_last) begin
          state_next = ST_FIX;
        end
      end
      ST_FIX: begin
        // The output register is free when empty or being taken this cycle.
        if (!rsp_valid || !rsp_stall) begin
          cmd.commit = 1'b1;
          state_next = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  assign rsp_valid_next = cmd.commit | (rsp_valid & rsp_stall);

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      rsp_valid <= 1'b0;
    end else begin
      state     <= state_next;
      rsp_valid <= rsp_valid_next;
    end
  end

endmodule

`default_nettype wire
